// File: rtl/efms_pkg.sv
`default_nettype none

package efms_pkg;

  // Default queue depth and the fixed timestamp width
  localparam int DEPTH_DEF = 16;
  localparam int STAMP_W   = 63;

  // Operation codes carried by in_opcode
  typedef enum logic [1:0] {
    OP_ENQ = 2'd0,
    OP_DEQ = 2'd1,
    OP_UPD = 2'd2
  } op_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // Which stored fields a result carries
  typedef enum logic [1:0] {
    RES_NONE  = 2'd0,
    RES_STAMP = 2'd1,
    RES_ENTRY = 2'd2
  } res_sel_t;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_DEQ  = 2'd1,
    S_SCAN = 2'd2
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic     enq;
    logic     start_scan;
    logic     deq;
    logic     advance;
    logic     clear_flag;
    logic     res_load;
    status_t  res_status;
    res_sel_t res_sel;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic empty;
    logic full;
    logic match;
    logic last;
    logic out_hold;
  } sts_t;

endpackage

`default_nettype wire

// File: rtl/expiry_fifo_with_mark_search.sv
// Expiry FIFO with mark search.
// Input channel (in_valid/in_ready) carries an opcode, a 63-bit timestamp and
// a flag; the result channel (out_valid/out_ready) returns one status,
// timestamp, flag and now-empty indication for every input transfer.
// Enqueue, an unused opcode and any operation on an empty queue give their
// result in the cycle after the transfer. Dequeue passes through the S_DEQ
// state first, as the entry store has a registered read port. Update walks the
// ring from the front one entry per cycle through that same read port, in the
// S_SCAN state, until an entry matches or the last live entry is inspected.
// One item is worked on at a time; the next input transfer is taken as soon
// as the controller is idle and the output register is empty or is being
// transferred in that cycle.
// If the receiver stalls, the result stays in the output register and the
// input side is held off once the current item is finished.
// Reset (rst_n low, synchronous) empties the queue and clears out_valid; the
// stored entries are not cleared, as only live entries are ever read.
`default_nettype none

module expiry_fifo_with_mark_search #(
  parameter int DEPTH = efms_pkg::DEPTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [1:0]                   in_opcode,
  input  wire logic [efms_pkg::STAMP_W-1:0] in_stamp_in,
  input  wire logic                         in_flag_in,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [1:0]                        out_status,
  output logic [efms_pkg::STAMP_W-1:0]      out_stamp_out,
  output logic                              out_flag_out,
  output logic                              out_now_empty
);
  import efms_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencing of each operation
  efms_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_ready  (in_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Ring store, pointers, search compare and output register
  efms_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_stamp_in   (in_stamp_in),
    .in_flag_in    (in_flag_in),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_stamp_out (out_stamp_out),
    .out_flag_out  (out_flag_out),
    .out_now_empty (out_now_empty)
  );

endmodule

`default_nettype wire

// File: rtl/efms_ctrl.sv
`default_nettype none

module efms_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic [1:0]    in_opcode,
  output logic               in_ready,
  input  wire efms_pkg::sts_t sts,
  output efms_pkg::cmd_t     cmd
);
  import efms_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  // A new item is taken only when idle and the result register is free
  assign in_ready = (state_r == S_IDLE) && !sts.out_hold;
  assign accept   = in_valid && in_ready;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && !sts.empty) begin
          if (op_t'(in_opcode) == OP_DEQ) begin
            state_nxt = S_DEQ;
          end else if (op_t'(in_opcode) == OP_UPD) begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_DEQ: begin
        state_nxt = S_IDLE;
      end
      S_SCAN: begin
        if (sts.match || sts.last) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Command outputs
  always_comb begin
    cmd            = '0;
    cmd.res_status = ST_OK;
    cmd.res_sel    = RES_NONE;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (op_t'(in_opcode))
            OP_ENQ: begin
              cmd.res_load = 1'b1;
              if (sts.full) begin
                cmd.res_status = ST_FULL;
              end else begin
                cmd.enq = 1'b1;
              end
            end
            OP_DEQ: begin
              if (sts.empty) begin
                cmd.res_load   = 1'b1;
                cmd.res_status = ST_EMPTY;
              end
            end
            OP_UPD: begin
              if (sts.empty) begin
                cmd.res_load   = 1'b1;
                cmd.res_status = ST_EMPTY;
              end else begin
                cmd.start_scan = 1'b1;
              end
            end
            default: begin
              cmd.res_load = 1'b1;
            end
          endcase
        end
      end
      S_DEQ: begin
        cmd.deq      = 1'b1;
        cmd.res_load = 1'b1;
        cmd.res_sel  = RES_ENTRY;
      end
      S_SCAN: begin
        if (sts.match) begin
          cmd.clear_flag = 1'b1;
          cmd.res_load   = 1'b1;
          cmd.res_sel    = RES_STAMP;
        end else if (sts.last) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_NOT_FOUND;
        end else begin
          cmd.advance = 1'b1;
        end
      end
      default: begin
        cmd.res_load = 1'b0;
      end
    endcase
  end

  // A result is only produced while the result register is free
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_load |-> !sts.out_hold)
    else $error("result loaded while output register still held");

  // A scan start, given only on a non-empty queue, always enters the scan state
  a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start_scan |=> (state_r == S_SCAN))
    else $error("scan start did not enter scan state");

  // The dequeue state always returns to idle in the next cycle
  a_deq_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DEQ) |=> (state_r == S_IDLE))
    else $error("dequeue state did not return to idle");

endmodule

`default_nettype wire

// File: rtl/efms_dpath.sv
`default_nettype none

module efms_dpath #(
  parameter int DEPTH = efms_pkg::DEPTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic [efms_pkg::STAMP_W-1:0] in_stamp_in,
  input  wire logic                         in_flag_in,
  input  wire efms_pkg::cmd_t               cmd,
  output efms_pkg::sts_t                    sts,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [1:0]                        out_status,
  output logic [efms_pkg::STAMP_W-1:0]      out_stamp_out,
  output logic                              out_flag_out,
  output logic                              out_now_empty
);
  import efms_pkg::*;

  localparam int PTR_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int WORD_W = STAMP_W + 1;

  // Entry store: timestamp above the flag bit
  logic [WORD_W-1:0] mem [DEPTH];

  logic [PTR_W-1:0]   head_r, tail_r, scan_r;
  logic [PTR_W-1:0]   head_nxt, tail_nxt, scan_nxt;
  logic [CNT_W-1:0]   count_r, remain_r;
  logic [STAMP_W-1:0] key_r;
  logic [WORD_W-1:0]  rd_data_r;
  logic [PTR_W-1:0]   rd_addr, wr_addr;
  logic [WORD_W-1:0]  wr_data;
  logic               wr_en;
  logic [STAMP_W-1:0] rd_stamp;
  logic               rd_flag;

  logic               out_valid_r;
  logic [1:0]         out_status_r;
  logic [STAMP_W-1:0] out_stamp_r;
  logic               out_flag_r;
  logic               out_empty_r;
  logic [STAMP_W-1:0] res_stamp;
  logic               res_flag;
  logic               res_empty;

  assign rd_stamp = rd_data_r[WORD_W-1:1];
  assign rd_flag  = rd_data_r[0];

  // Ring successors of the three pointers
  assign head_nxt = (head_r == PTR_W'(DEPTH - 1)) ? '0 : head_r + PTR_W'(1);
  assign tail_nxt = (tail_r == PTR_W'(DEPTH - 1)) ? '0 : tail_r + PTR_W'(1);
  assign scan_nxt = (scan_r == PTR_W'(DEPTH - 1)) ? '0 : scan_r + PTR_W'(1);

  // Memory port selection: scan reads the next slot, otherwise the front
  assign rd_addr = cmd.advance ? scan_nxt : head_r;
  assign wr_en   = cmd.enq || cmd.clear_flag;
  assign wr_addr = cmd.enq ? tail_r : scan_r;
  assign wr_data = cmd.enq ? {in_stamp_in, in_flag_in} : {rd_stamp, 1'b0};

  // Entry store with registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Queue pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      if (cmd.enq) begin
        tail_r  <= tail_nxt;
        count_r <= count_r + CNT_W'(1);
      end else if (cmd.deq) begin
        head_r  <= head_nxt;
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  // Search position, entries left to inspect and the search time
  always_ff @(posedge clk) begin
    if (cmd.start_scan) begin
      scan_r   <= head_r;
      remain_r <= count_r;
      key_r    <= in_stamp_in;
    end else if (cmd.advance) begin
      scan_r   <= scan_nxt;
      remain_r <= remain_r - CNT_W'(1);
    end
  end

  // Status towards the controller
  assign sts.empty    = (count_r == '0);
  assign sts.full     = (count_r == CNT_W'(DEPTH));
  assign sts.match    = (rd_stamp >= key_r);
  assign sts.last     = (remain_r == CNT_W'(1));
  assign sts.out_hold = out_valid_r && !out_ready;

  // Result fields
  always_comb begin
    res_stamp = '0;
    res_flag  = 1'b0;
    case (cmd.res_sel)
      RES_STAMP: begin
        res_stamp = rd_stamp;
      end
      RES_ENTRY: begin
        res_stamp = rd_stamp;
        res_flag  = rd_flag;
      end
      default: begin
        res_stamp = '0;
      end
    endcase
    if (cmd.deq) begin
      res_empty = (count_r == CNT_W'(1));
    end else if (cmd.enq) begin
      res_empty = 1'b0;
    end else begin
      res_empty = sts.empty;
    end
  end

  // Output register: holds a result until its transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_status_r <= cmd.res_status;
      out_stamp_r  <= res_stamp;
      out_flag_r   <= res_flag;
      out_empty_r  <= res_empty;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_stamp_out = out_stamp_r;
  assign out_flag_out  = out_flag_r;
  assign out_now_empty = out_empty_r;

  // Occupancy never exceeds the ring size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count beyond depth");

  // Pointers meet exactly when the ring is empty or full
  a_ptr_meet: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r == tail_r) == (sts.empty || sts.full))
    else $error("head and tail disagree with entry count");

  // No write into a full ring
  a_enq_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.enq |-> !sts.full)
    else $error("enqueue into a full ring");

  // A dequeue removes exactly one entry
  a_deq_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.deq |=> (count_r == $past(count_r) - CNT_W'(1)))
    else $error("dequeue did not decrement the entry count");

endmodule

`default_nettype wire

// File: dv/efms_checker.sv
`default_nettype none

module efms_checker import efms_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_ready,
  input  wire logic [1:0]         in_opcode,
  input  wire logic [STAMP_W-1:0] in_stamp_in,
  input  wire logic               in_flag_in,
  input  wire logic               out_valid,
  input  wire logic               out_ready,
  input  wire logic [1:0]         out_status,
  input  wire logic [STAMP_W-1:0] out_stamp_out,
  input  wire logic               out_flag_out,
  input  wire logic               out_now_empty,
  output int                      fail_count,
  output int                      awaited_count,
  output int                      compared_count
);

  // One result as the receiver should see it.
  typedef struct packed {
    status_t            status;
    logic [STAMP_W-1:0] stamp;
    logic               flag;
    logic               now_empty;
  } queue_result_t;

  // Shadow copy of the ring and its pointers.
  logic [STAMP_W-1:0] ring_stamps [DEPTH];
  logic               ring_flags  [DEPTH];
  int                 front_slot;
  int                 back_slot;
  int                 live_entries;

  queue_result_t awaited_results [$];

  // Applies one operation to the shadow ring and returns what it should report.
  function automatic queue_result_t apply_queue_op(input logic [1:0] op,
                                                   input logic [STAMP_W-1:0] stamp,
                                                   input logic flag);
    queue_result_t res;
    int            slot;
    int            k;
    bit            found;
    res = '0;
    res.status = ST_OK;
    case (op)
      OP_ENQ: begin
        if (live_entries >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          ring_stamps[back_slot] = stamp;
          ring_flags[back_slot]  = flag;
          back_slot = (back_slot + 1) % DEPTH;
          live_entries++;
        end
      end
      OP_DEQ: begin
        if (live_entries == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.stamp  = ring_stamps[front_slot];
          res.flag   = ring_flags[front_slot];
          front_slot = (front_slot + 1) % DEPTH;
          live_entries--;
        end
      end
      OP_UPD: begin
        if (live_entries == 0) begin
          res.status = ST_EMPTY;
        end else begin
          // Walk from the front to the first stamp not below the search time.
          found = 1'b0;
          slot  = front_slot;
          for (k = 0; k < live_entries && !found; k++) begin
            if (ring_stamps[slot] >= stamp) begin
              found = 1'b1;
            end else begin
              slot = (slot + 1) % DEPTH;
            end
          end
          if (found) begin
            ring_flags[slot] = 1'b0;
            res.stamp = ring_stamps[slot];
          end else begin
            res.status = ST_NOT_FOUND;
          end
        end
      end
      default: ;
    endcase
    res.now_empty = (live_entries == 0);
    return res;
  endfunction

  // Sampling on the falling edge sees settled values for the coming transfer.
  always @(negedge clk) begin : watch_channels
    queue_result_t want;
    if (!rst_n) begin
      front_slot   = 0;
      back_slot    = 0;
      live_entries = 0;
      awaited_results.delete();
      fail_count     = 0;
      compared_count = 0;
    end else begin
      // The result side is handled first: it can never belong to this input.
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("unexpected result transfer: status %0d stamp %h flag %b empty %b",
                     out_status, out_stamp_out, out_flag_out, out_now_empty);
          end
        end else begin
          want = awaited_results.pop_front();
          compared_count++;
          if (out_status !== want.status || out_stamp_out !== want.stamp ||
              out_flag_out !== want.flag || out_now_empty !== want.now_empty) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("result %0d differs: expected status %0d stamp %h flag %b empty %b",
                       compared_count, want.status, want.stamp, want.flag, want.now_empty);
              $display("  got status %0d stamp %h flag %b empty %b",
                       out_status, out_stamp_out, out_flag_out, out_now_empty);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        awaited_results.push_back(apply_queue_op(in_opcode, in_stamp_in, in_flag_in));
      end
    end
    awaited_count = awaited_results.size();
  end

endmodule

`default_nettype wire

// File: dv/testbench.sv
`default_nettype none

module testbench;
  import efms_pkg::*;

  localparam int          CYCLE_LIMIT  = 400000;
  localparam int          RANDOM_ITEMS = 1600;
  localparam logic [1:0]  OP_SPARE     = 2'd3;
  localparam logic [STAMP_W-1:0] STAMP_MAX = '1;

  // Operation mixes for the random part, each steering the queue fill level.
  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN, MIX_SEARCH} mix_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  wire logic          in_ready;
  logic [1:0]         in_opcode = OP_ENQ;
  logic [STAMP_W-1:0] in_stamp_in = '0;
  logic               in_flag_in = 1'b0;
  wire logic          out_valid;
  logic               out_ready = 1'b0;
  wire logic [1:0]    out_status;
  wire logic [STAMP_W-1:0] out_stamp_out;
  wire logic          out_flag_out;
  wire logic          out_now_empty;

  int  fail_count;
  int  awaited_count;
  int  compared_count;
  int  cycle_count = 0;
  int  op_count [4] = '{0, 0, 0, 0};
  bit  no_idle = 1'b0;
  int  ready_hold = 0;
  bit  out_taken = 1'b0;

  expiry_fifo_with_mark_search dut (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_opcode, .in_stamp_in, .in_flag_in,
    .out_valid, .out_ready, .out_status, .out_stamp_out, .out_flag_out,
    .out_now_empty
  );

  efms_checker #(.DEPTH(DEPTH_DEF)) u_checker (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_opcode, .in_stamp_in, .in_flag_in,
    .out_valid, .out_ready, .out_status, .out_stamp_out, .out_flag_out,
    .out_now_empty,
    .fail_count, .awaited_count, .compared_count
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Cycle count and overall time limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Note the result transfer half a cycle early so the receiver can react.
  always @(negedge clk) begin
    out_taken <= out_valid && out_ready;
  end

  // Receiver: after each result transfer it stalls for a drawn number of cycles, unless no_idle is set.
  always @(posedge clk) begin : receiver
    int draw;
    if (!rst_n) begin
      out_ready  <= 1'b0;
      ready_hold <= 1;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
      out_ready  <= (ready_hold == 1);
    end else if (out_taken) begin
      if (no_idle) begin
        out_ready <= 1'b1;
      end else begin
        draw = $urandom_range(0, 4);
        ready_hold <= draw;
        out_ready  <= (draw == 0);
      end
    end
  end

  // Stamps lean towards a small range so that searches both hit and miss.
  function automatic logic [STAMP_W-1:0] random_stamp();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return STAMP_MAX;
      2, 3:    return STAMP_W'({$urandom, $urandom});
      default: return STAMP_W'($urandom_range(0, 1000));
    endcase
  endfunction

  function automatic logic [1:0] pick_op(input mix_t mix);
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) begin
      return OP_SPARE;
    end
    case (mix)
      MIX_FILL:  return (r < 65) ? OP_ENQ : (r < 85) ? OP_DEQ : OP_UPD;
      MIX_DRAIN: return (r < 30) ? OP_ENQ : (r < 75) ? OP_DEQ : OP_UPD;
      MIX_EVEN:  return (r < 45) ? OP_ENQ : (r < 75) ? OP_DEQ : OP_UPD;
      default:   return (r < 35) ? OP_ENQ : (r < 50) ? OP_DEQ : OP_UPD;
    endcase
  endfunction

  // Presents one operation after a drawn gap and returns once it is transferred.
  task automatic send_op(input logic [1:0] op, input logic [STAMP_W-1:0] stamp,
                         input logic flag);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_opcode   <= op;
    in_stamp_in <= stamp;
    in_flag_in  <= flag;
    op_count[op]++;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  initial begin
    mix_t mix;
    int   i;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: operations on an empty queue.
    send_op(OP_DEQ, STAMP_MAX, 1'b1);
    send_op(OP_UPD, '0, 1'b0);
    send_op(OP_SPARE, STAMP_MAX, 1'b1);
    // Extreme stamps; a search for the largest time clears the front flag.
    send_op(OP_ENQ, STAMP_MAX, 1'b1);
    send_op(OP_ENQ, '0, 1'b0);
    send_op(OP_UPD, STAMP_MAX, 1'b1);
    send_op(OP_DEQ, '0, 1'b0);
    // A search that misses, then one that hits the zero stamp.
    send_op(OP_UPD, STAMP_W'(1), 1'b0);
    send_op(OP_UPD, '0, 1'b1);
    send_op(OP_SPARE, '0, 1'b0);
    send_op(OP_DEQ, '0, 1'b0);
    // Fill the ring completely, then overflow it and search the full ring.
    for (i = 0; i < DEPTH_DEF; i++) begin
      send_op(OP_ENQ, random_stamp(), 1'($urandom_range(0, 1)));
    end
    send_op(OP_ENQ, STAMP_MAX, 1'b1);
    send_op(OP_UPD, STAMP_MAX, 1'b0);

    // Random part: the mix and the idling style change every 64 operations.
    mix = MIX_EVEN;
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 64 == 0) begin
        mix     = mix_t'($urandom_range(0, 3));
        no_idle = ($urandom_range(0, 3) == 0);
      end
      send_op(pick_op(mix), random_stamp(), 1'($urandom_range(0, 1)));
    end
    in_valid <= 1'b0;
    no_idle  = 1'b0;

    // Drain, then allow a full search's worth of cycles for stray results.
    while (awaited_count != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Sent %0d enqueues, %0d dequeues, %0d updates and %0d spare opcodes.",
             op_count[OP_ENQ], op_count[OP_DEQ], op_count[OP_UPD], op_count[OP_SPARE]);
    $display("Compared %0d results; %0d failures counted.", compared_count, fail_count);
    if (fail_count == 0 && awaited_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
